// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

// ===== src/pf_pkg.sv =====
// Package for the Playfair digraph cipher: payload structs, codes, symbol maps.
// No dependencies; used by the top level, pf_cell_step and the checker.
`timescale 1ns / 1ps

package pf_pkg;

  localparam int GRID_SIDE_DEF = 6;
  localparam int SYM_MAX_W     = 6;

  typedef logic [SYM_MAX_W-1:0] sym_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] symbol_a;
    logic [7:0] symbol_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_a;
    logic [7:0] result_b;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic valid;
    sym_t sym;
  } sym_lookup_t;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_KEY    = 3'd1;
  localparam logic [2:0] OP_FINISH = 3'd2;
  localparam logic [2:0] OP_ENCODE = 3'd3;
  localparam logic [2:0] OP_DECODE = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR  = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  localparam sym_t SYM_I      = 6'd8;
  localparam sym_t SYM_J      = 6'd9;
  localparam sym_t SYM_DIGITS = 6'd26;

  // ASCII byte to symbol index; valid low for a byte outside the alphabet.
  function automatic sym_lookup_t to_symbol(input logic [7:0] b, input int unsigned grid);
    sym_lookup_t r;
    logic [7:0]  c;
    sym_t        k;
    r.valid = 1'b0;
    r.sym   = '0;
    c       = b;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      c = c + CASE_GAP;
    end
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      k = SYM_MAX_W'(c - CH_LOWER_A);
      if (grid == 5) begin
        if (k > SYM_J) begin
          k = k - 6'd1;
        end else if (k == SYM_J) begin
          k = SYM_I;
        end
      end
      r.valid = 1'b1;
      r.sym   = k;
    end else if (grid == 6 && c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      r.valid = 1'b1;
      r.sym   = SYM_MAX_W'(c - CH_DIGIT_0) + SYM_DIGITS;
    end
    return r;
  endfunction

  // Symbol index to lowercase ASCII letter, or digit byte for the digit symbols.
  function automatic logic [7:0] to_ascii(input sym_t sym, input int unsigned grid);
    logic [7:0] r;
    if (grid == 5) begin
      r = CH_LOWER_A + 8'(sym) + ((sym >= SYM_J) ? 8'd1 : 8'd0);
    end else if (sym < SYM_DIGITS) begin
      r = CH_LOWER_A + 8'(sym);
    end else begin
      r = CH_DIGIT_0 + 8'(sym - SYM_DIGITS);
    end
    return r;
  endfunction

endpackage

// ===== src/playfair_digraph_cipher.sv =====
// Top level of the Playfair digraph cipher: sequencer, square bookkeeping, result register.
// Depends on pf_pkg, pf_ram and pf_cell_step.
`timescale 1ns / 1ps

// Channel   Direction  Payload      Transfer when
// in_*      input      in_item_t    in_valid && in_ready
// out_*     output     out_item_t   out_valid && out_ready
//
// Clear and a key character complete at the transfer in S_IDLE; finish steps S_WALK over every symbol,
// walking one symbol per cycle through both square stores.
// An encode or decode pair passes S_POS_B, S_CELL_A, S_CELL_B, S_FINAL: two position reads
// and two square reads, each on one RAM port with registered data, sharing one grid unit.
// Reset clears the sequencer, used flags, fill count and ready bit; the two stores
// are not cleared and their read data is only used after the square is finished.
// A pair is not accepted while the result register is full and not draining;
// a finished pair waits in its last state while the result register is still full.

module playfair_digraph_cipher #(
  parameter int GRID_SIDE = pf_pkg::GRID_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pf_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pf_pkg::out_item_t out_data
);

  import pf_pkg::*;

  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int CRD_W  = $clog2(GRID_SIDE);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int POS_W  = 2 * CRD_W;
  localparam int unsigned GS_U = GRID_SIDE;

  localparam logic [CNT_W-1:0]  CELLS_CNT = CNT_W'(CELLS);
  localparam logic [CELL_W-1:0] LAST_SYM  = CELL_W'(CELLS - 1);
  localparam logic [CRD_W-1:0]  LAST_CRD  = CRD_W'(GRID_SIDE - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_POS_B,
    S_CELL_A,
    S_CELL_B,
    S_FINAL
  } state_t;

  state_t            state_r, state_nxt;
  logic [CELLS-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic [CRD_W-1:0]  fill_row_r, fill_row_nxt;
  logic [CRD_W-1:0]  fill_col_r, fill_col_nxt;
  logic              ready_r, ready_nxt;
  logic [CELL_W-1:0] walk_r, walk_nxt;
  logic [CELL_W-1:0] sb_r, sb_nxt;
  logic              decode_r, decode_nxt;
  logic [POS_W-1:0]  pa_r, pa_nxt;
  logic [POS_W-1:0]  pb_r, pb_nxt;
  logic [CELL_W-1:0] ka_r, ka_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  sym_lookup_t       look_a, look_b;
  logic              in_fire, is_pair, out_free;
  logic              place_req, place_en;
  logic [CELL_W-1:0] place_sym;

  logic              ks_we, sp_we;
  logic [CELL_W-1:0] ks_addr, ks_wdata, ks_rdata;
  logic [CELL_W-1:0] sp_addr;
  logic [POS_W-1:0]  sp_wdata, sp_rdata;

  logic [CRD_W-1:0]  own_row, own_col, oth_row, oth_col;
  logic [CELL_W-1:0] step_idx;

  // Input decode and handshake.
  always_comb begin
    look_a   = to_symbol(in_data.symbol_a, GS_U);
    look_b   = to_symbol(in_data.symbol_b, GS_U);
    is_pair  = (in_data.operation == OP_ENCODE) || (in_data.operation == OP_DECODE);
    out_free = !out_valid_r || out_ready;
    // Hold off any pair while the result register cannot take a new result:
    // an error result is written right at the transfer.
    in_ready = (state_r == S_IDLE) && (out_free || !is_pair);
    in_fire  = in_valid && in_ready;
  end

  // Placement of one symbol into the square, shared by key characters and the finish walk.
  always_comb begin
    place_sym = (state_r == S_WALK) ? walk_r : look_a.sym[CELL_W-1:0];
    place_req = (state_r == S_WALK) ||
                (in_fire && (in_data.operation == OP_KEY) && !ready_r && look_a.valid);
    place_en  = place_req && (fill_cnt_r < CELLS_CNT) && !used_r[place_sym];
  end

  // Store ports.
  always_comb begin
    ks_we    = place_en;
    ks_wdata = place_sym;
    ks_addr  = place_en ? fill_cnt_r[CELL_W-1:0] : step_idx;
    sp_we    = place_en;
    sp_wdata = {fill_row_r, fill_col_r};
    sp_addr  = (state_r == S_POS_B) ? sb_r : place_sym;
  end

  // Feed the grid unit: first letter against partner straight from the store, then swap.
  always_comb begin
    if (state_r == S_CELL_A) begin
      own_row = pa_r[POS_W-1:CRD_W];
      own_col = pa_r[CRD_W-1:0];
      oth_row = sp_rdata[POS_W-1:CRD_W];
      oth_col = sp_rdata[CRD_W-1:0];
    end else begin
      own_row = pb_r[POS_W-1:CRD_W];
      own_col = pb_r[CRD_W-1:0];
      oth_row = pa_r[POS_W-1:CRD_W];
      oth_col = pa_r[CRD_W-1:0];
    end
  end

  pf_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_key_square (
    .clk   (clk),
    .we    (ks_we),
    .addr  (ks_addr),
    .wdata (ks_wdata),
    .rdata (ks_rdata)
  );

  pf_ram #(
    .WIDTH (POS_W),
    .DEPTH (CELLS)
  ) u_symbol_pos (
    .clk   (clk),
    .we    (sp_we),
    .addr  (sp_addr),
    .wdata (sp_wdata),
    .rdata (sp_rdata)
  );

  pf_cell_step #(
    .GRID_SIDE (GRID_SIDE),
    .CRD_W     (CRD_W),
    .CELL_W    (CELL_W)
  ) u_cell_step (
    .decode   (decode_r),
    .own_row  (own_row),
    .own_col  (own_col),
    .oth_row  (oth_row),
    .oth_col  (oth_col),
    .step_idx (step_idx)
  );

  // Sequencer and bookkeeping.
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_row_nxt  = fill_row_r;
    fill_col_nxt  = fill_col_r;
    ready_nxt     = ready_r;
    walk_nxt      = walk_r;
    sb_nxt        = sb_r;
    decode_nxt    = decode_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    ka_nxt        = ka_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    // Advance the fill pointer in row-major order.
    if (place_en) begin
      used_nxt[place_sym] = 1'b1;
      fill_cnt_nxt        = fill_cnt_r + CNT_W'(1);
      if (fill_col_r == LAST_CRD) begin
        fill_col_nxt = '0;
        fill_row_nxt = fill_row_r + CRD_W'(1);
      end else begin
        fill_col_nxt = fill_col_r + CRD_W'(1);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          priority if (in_data.operation == OP_CLEAR) begin
            used_nxt     = '0;
            fill_cnt_nxt = '0;
            fill_row_nxt = '0;
            fill_col_nxt = '0;
            ready_nxt    = 1'b0;
          end else if (in_data.operation == OP_FINISH) begin
            if (!ready_r) begin
              walk_nxt  = '0;
              state_nxt = S_WALK;
            end
          end else if (is_pair) begin
            priority if (!ready_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{result_a: 8'd0, result_b: 8'd0, status: ST_NOT_READY};
            end else if (!look_a.valid || !look_b.valid) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{result_a: 8'd0, result_b: 8'd0, status: ST_BAD_CHAR};
            end else begin
              // First position read is already issued this cycle.
              sb_nxt     = look_b.sym[CELL_W-1:0];
              decode_nxt = (in_data.operation == OP_DECODE);
              state_nxt  = S_POS_B;
            end
          end else begin
            // Key characters are placed above; unused codes drop.
          end
        end
      end
      S_WALK: begin
        walk_nxt = walk_r + CELL_W'(1);
        if (walk_r == LAST_SYM) begin
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_POS_B: begin
        pa_nxt    = sp_rdata;
        state_nxt = S_CELL_A;
      end
      S_CELL_A: begin
        pb_nxt    = sp_rdata;
        state_nxt = S_CELL_B;
      end
      S_CELL_B: begin
        // First square read lands now; the second one is issued.
        ka_nxt    = ks_rdata;
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        // Second square read stays on the port until the result register frees.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_a: to_ascii(SYM_MAX_W'(ka_r), GS_U),
                            result_b: to_ascii(SYM_MAX_W'(ks_rdata), GS_U),
                            status:   ST_OK};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      fill_cnt_r  <= '0;
      fill_row_r  <= '0;
      fill_col_r  <= '0;
      ready_r     <= 1'b0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_row_r  <= fill_row_nxt;
      fill_col_r  <= fill_col_nxt;
      ready_r     <= ready_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sb_r       <= sb_nxt;
    decode_r   <= decode_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    ka_r       <= ka_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/pf_ram.sv =====
// Generic single-port RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module pf_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/pf_cell_step.sv =====
// Shared grid unit: maps one letter's position and its partner's to the output cell.
// Depends on pf_pkg only for the default grid side.
`timescale 1ns / 1ps

module pf_cell_step #(
  parameter int GRID_SIDE = pf_pkg::GRID_SIDE_DEF,
  parameter int CRD_W     = $clog2(GRID_SIDE),
  parameter int CELL_W    = $clog2(GRID_SIDE * GRID_SIDE)
) (
  input  logic              decode,
  input  logic [CRD_W-1:0]  own_row,
  input  logic [CRD_W-1:0]  own_col,
  input  logic [CRD_W-1:0]  oth_row,
  input  logic [CRD_W-1:0]  oth_col,
  output logic [CELL_W-1:0] step_idx
);

  localparam logic [CRD_W-1:0]  LAST = CRD_W'(GRID_SIDE - 1);
  localparam logic [CELL_W-1:0] SIDE = CELL_W'(GRID_SIDE);

  logic [CRD_W-1:0] row_sh, col_sh, row_o, col_o;

  always_comb begin
    // Wrap one step forward on encode, one step back on decode.
    if (decode) begin
      col_sh = (own_col == '0) ? LAST : own_col - CRD_W'(1);
      row_sh = (own_row == '0) ? LAST : own_row - CRD_W'(1);
    end else begin
      col_sh = (own_col == LAST) ? '0 : own_col + CRD_W'(1);
      row_sh = (own_row == LAST) ? '0 : own_row + CRD_W'(1);
    end
    priority if (own_row == oth_row) begin
      row_o = own_row;
      col_o = col_sh;
    end else if (own_col == oth_col) begin
      row_o = row_sh;
      col_o = own_col;
    end else begin
      row_o = own_row;
      col_o = oth_col;
    end
    step_idx = CELL_W'(CELL_W'(row_o) * SIDE) + CELL_W'(col_o);
  end

endmodule

// ===== src/pf_checker.sv =====
// Port-level checker for the Playfair digraph cipher, bound to the top level.
// Depends on pf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input pf_pkg::in_item_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input pf_pkg::out_item_t out_data
);

  import pf_pkg::*;

  logic in_xfer, non_pair;

  assign in_xfer  = in_valid && in_ready;
  assign non_pair = (in_data.operation != OP_ENCODE) && (in_data.operation != OP_DECODE);

  // A stalled result holds its payload.
  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // Only pair operations produce results.
  `ASSERT_NXT(a_no_spurious, in_xfer && non_pair && !out_valid, !out_valid)
  // Error results carry zero characters.
  `ASSERT_IMP(a_err_zero, out_valid && (out_data.status != ST_OK),
              (out_data.result_a == 8'd0) && (out_data.result_b == 8'd0))
  // Status stays within its defined codes.
  `ASSERT_IMP(a_status_code, out_valid,
              (out_data.status == ST_OK) || (out_data.status == ST_BAD_CHAR) ||
              (out_data.status == ST_NOT_READY))

endmodule

bind playfair_digraph_cipher pf_checker u_pf_checker (.*);
